>>> rtl/core/bdda_pkg.sv
package bdda_pkg;

	// limits and reset values
	localparam int          MAX_WORKING_DAYS = 4095;
	localparam logic [13:0] MAX_YEAR         = 14'd9999;
	localparam logic [6:0]  WEEKEND_RESET    = 7'd96;
	localparam logic [6:0]  WEEKEND_ALL      = 7'h7f;

	// divide by 100 through a reciprocal, exact for values below 10000
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	// month codes
	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	// weekday codes
	localparam logic [2:0] WD_SUNDAY   = 3'd0;
	localparam logic [2:0] WD_SATURDAY = 3'd6;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CAL,
		ST_WD,
		ST_COUNT,
		ST_SKIP,
		ST_FINISH
	} state_t;

	// running date plus the year residues that give the leap rule
	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [1:0]  y4;    // year mod 4
		logic [6:0]  y100;  // year mod 100
		logic [1:0]  q4;    // (year / 100) mod 4
		logic [2:0]  wd;
	} cal_t;

	// gregorian leap rule from residues
	function automatic logic leap_of(input logic [6:0] y100, input logic [1:0] q4,
		input logic [1:0] y4);
		logic lp;
		if (y100 == 7'd0) begin
			lp = (q4 == 2'd0);
		end else begin
			lp = (y4 == 2'd0);
		end
		return lp;
	endfunction

	// days in month, zero for a month code outside the year
	function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
		logic [4:0] n;
		case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
			4'd2:                                       n = leap ? 5'd29 : 5'd28;
			default:                                    n = 5'd0;
		endcase
		return n;
	endfunction

	// (31 * mm) / 12 term of the weekday formula, by month
	function automatic logic [4:0] month_offset(input logic [3:0] month);
		logic [4:0] n;
		case (month)
			4'd1:    n = 5'd28;
			4'd2:    n = 5'd31;
			4'd3:    n = 5'd2;
			4'd4:    n = 5'd5;
			4'd5:    n = 5'd7;
			4'd6:    n = 5'd10;
			4'd7:    n = 5'd12;
			4'd8:    n = 5'd15;
			4'd9:    n = 5'd18;
			4'd10:   n = 5'd20;
			4'd11:   n = 5'd23;
			4'd12:   n = 5'd25;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

	// mod 7 by folding octal digits, since 8 is 1 mod 7
	function automatic logic [2:0] mod7(input logic [14:0] x);
		logic [5:0] s1;
		logic [3:0] s2;
		logic [3:0] s3;
		s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
		s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
		s3 = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
		return s3[2:0];
	endfunction

endpackage

>>> rtl/core/business_day_date_adder.sv
// sequence: multiply, calendar setup and weekday states, then the count loop, the skip
//   loop and an output load; a rejected item goes from the weekday state to the output load
// throughput: one item at a time; the next item is taken in idle, once the last result
//   is loaded into the output register, which waits until the output is free
// a finished result waits in the output register while the next item is taken
// reset: weekend mask returns to Friday and Saturday, sequencer idle, no result
module business_day_date_adder #(
	parameter int MAX_WORKING_DAYS = bdda_pkg::MAX_WORKING_DAYS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data,   // weekend_mask
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,       // start_day, start_month, start_year, working_days
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,       // return_day, return_month, return_year, return_weekday
	output logic [0:0]  m_tuser        // bad_date
);

	bdda_pkg::state_t state_q, state_d;

	logic [6:0]  mask_q;
	logic [4:0]  sd_q;
	logic [3:0]  sm_q;
	logic [13:0] sy_q;
	logic [13:0] yy_q;
	logic [11:0] target_q;
	logic [11:0] count_q;
	logic [26:0] prod_q;
	logic [14:0] sum_q;
	logic [2:0]  wd0_q;
	logic        inval_q;
	logic        bad_q;
	bdda_pkg::cal_t cal_q;
	bdda_pkg::cal_t cal_nxt;
	logic        step_ovf;

	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic        m_tuser_q;

	logic [4:0]  in_day;
	logic [3:0]  in_month;
	logic [13:0] in_year;
	logic [11:0] in_days;
	logic [11:0] in_target;
	logic        in_a;

	logic [6:0]  q_yy;
	logic [6:0]  r_yy;
	logic [6:0]  r_y;
	logic [6:0]  q_y;
	logic        start_leap;
	logic [4:0]  start_dim;
	logic        start_ok;
	logic [14:0] wd_sum;

	logic        accept;
	logic        out_free;
	logic        is_weekend;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == bdda_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// input unpacking and count clamp
	assign in_day    = s_tdata[4:0];
	assign in_month  = s_tdata[8:5];
	assign in_year   = s_tdata[22:9];
	assign in_days   = s_tdata[34:23];
	assign in_target = (32'(in_days) > 32'(MAX_WORKING_DAYS)) ? 12'(MAX_WORKING_DAYS) : in_days;
	assign in_a      = (in_month <= bdda_pkg::MONTH_FEB);

	// year / 100 from the registered product, then residues of the start year
	assign q_yy = prod_q[bdda_pkg::RECIP_SHIFT +: 7];
	assign r_yy = 7'(yy_q - 14'(q_yy) * 14'd100);
	always_comb begin
		r_y = r_yy;
		q_y = q_yy;
		if (yy_q != sy_q) begin
			if (r_yy == 7'd99) begin
				r_y = 7'd0;
				q_y = q_yy + 7'd1;
			end else begin
				r_y = r_yy + 7'd1;
			end
		end
	end
	assign start_leap = bdda_pkg::leap_of(r_y, q_y[1:0], sy_q[1:0]);
	assign start_dim  = bdda_pkg::days_in_month(sm_q, start_leap);
	assign start_ok   = (sy_q >= 14'd1) && (sy_q <= bdda_pkg::MAX_YEAR) &&
		(sm_q >= bdda_pkg::MONTH_JAN) && (sm_q <= bdda_pkg::MONTH_DEC) &&
		(sd_q >= 5'd1) && (sd_q <= start_dim);
	assign wd_sum = 15'(sd_q) + 15'(yy_q) + 15'(yy_q >> 2) - 15'(q_yy) + 15'(q_yy >> 2) +
		15'(bdda_pkg::month_offset(sm_q));

	// shared one-day stepper
	bdda_day_step u_step (
		.cur (cal_q),
		.nxt (cal_nxt),
		.ovf (step_ovf)
	);

	assign is_weekend = mask_q[cal_q.wd];

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bdda_pkg::ST_IDLE: begin
				if (accept) state_d = bdda_pkg::ST_MUL;
			end
			bdda_pkg::ST_MUL: begin
				state_d = bdda_pkg::ST_CAL;
			end
			bdda_pkg::ST_CAL: begin
				state_d = bdda_pkg::ST_WD;
			end
			bdda_pkg::ST_WD: begin
				if (inval_q || mask_q == bdda_pkg::WEEKEND_ALL) state_d = bdda_pkg::ST_FINISH;
				else state_d = bdda_pkg::ST_COUNT;
			end
			bdda_pkg::ST_COUNT: begin
				if (count_q >= target_q) state_d = bdda_pkg::ST_SKIP;
				else if (step_ovf) state_d = bdda_pkg::ST_FINISH;
			end
			bdda_pkg::ST_SKIP: begin
				if (!is_weekend || step_ovf) state_d = bdda_pkg::ST_FINISH;
			end
			bdda_pkg::ST_FINISH: begin
				if (out_free) state_d = bdda_pkg::ST_IDLE;
			end
			default: begin
				state_d = bdda_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bdda_pkg::ST_IDLE;
			mask_q     <= bdda_pkg::WEEKEND_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) mask_q <= cfg_wr_data;
			if (state_q == bdda_pkg::ST_FINISH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			bdda_pkg::ST_IDLE: begin
				if (accept) begin
					sd_q     <= in_day;
					sm_q     <= in_month;
					sy_q     <= in_year;
					yy_q     <= in_year - 14'(in_a);
					target_q <= in_target;
				end
			end
			bdda_pkg::ST_MUL: begin
				prod_q <= 27'(yy_q) * 27'(bdda_pkg::RECIP_100);
			end
			bdda_pkg::ST_CAL: begin
				sum_q      <= wd_sum;
				inval_q    <= !start_ok;
				cal_q.day  <= sd_q;
				cal_q.month <= sm_q;
				cal_q.year <= sy_q;
				cal_q.y4   <= sy_q[1:0];
				cal_q.y100 <= r_y;
				cal_q.q4   <= q_y[1:0];
			end
			bdda_pkg::ST_WD: begin
				wd0_q    <= bdda_pkg::mod7(sum_q);
				cal_q.wd <= bdda_pkg::mod7(sum_q);
				count_q  <= 12'd0;
				bad_q    <= inval_q || (mask_q == bdda_pkg::WEEKEND_ALL);
			end
			bdda_pkg::ST_COUNT: begin
				if (count_q < target_q) begin
					if (!is_weekend) count_q <= count_q + 12'd1;
					if (step_ovf) bad_q <= 1'b1;
					else cal_q <= cal_nxt;
				end
			end
			bdda_pkg::ST_SKIP: begin
				if (is_weekend) begin
					if (step_ovf) bad_q <= 1'b1;
					else cal_q <= cal_nxt;
				end
			end
			bdda_pkg::ST_FINISH: begin
				if (out_free) begin
					m_tuser_q <= bad_q;
					if (bad_q) begin
						m_tdata_q <= {6'd0, (inval_q ? bdda_pkg::WD_SUNDAY : wd0_q),
							sy_q, sm_q, sd_q};
					end else begin
						m_tdata_q <= {6'd0, cal_q.wd, cal_q.year, cal_q.month, cal_q.day};
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/core/bdda_day_step.sv
module bdda_day_step (
	input  bdda_pkg::cal_t cur,
	output bdda_pkg::cal_t nxt,
	output logic           ovf
);

	logic [4:0] dim;

	// length of the current month
	assign dim = bdda_pkg::days_in_month(cur.month,
		bdda_pkg::leap_of(cur.y100, cur.q4, cur.y4));

	// advance one day, flag a step past the last supported year
	always_comb begin
		nxt = cur;
		ovf = 1'b0;
		if (cur.day >= dim) begin
			nxt.day = 5'd1;
			if (cur.month >= bdda_pkg::MONTH_DEC) begin
				if (cur.year >= bdda_pkg::MAX_YEAR) begin
					ovf = 1'b1;
					nxt = cur;
				end else begin
					nxt.month = bdda_pkg::MONTH_JAN;
					nxt.year  = cur.year + 14'd1;
					nxt.y4    = cur.y4 + 2'd1;
					if (cur.y100 == 7'd99) begin
						nxt.y100 = 7'd0;
						nxt.q4   = cur.q4 + 2'd1;
					end else begin
						nxt.y100 = cur.y100 + 7'd1;
					end
				end
			end else begin
				nxt.month = cur.month + 4'd1;
			end
		end else begin
			nxt.day = cur.day + 5'd1;
		end
		if (!ovf) begin
			nxt.wd = (cur.wd == bdda_pkg::WD_SATURDAY) ? bdda_pkg::WD_SUNDAY : cur.wd + 3'd1;
		end
	end

endmodule

>>> test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// one vacation request as it goes into the block
	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [11:0] working_days;
	} vacation_t;

	// one return date as it comes out of the block
	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [2:0]  weekday;
		logic        bad;
	} return_t;

	localparam int CYCLE_LIMIT = 6000000;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [6:0]  cfg_wr_data = '0;
	logic        s_tvalid    = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata     = '0;   // start_day, start_month, start_year, working_days
	logic        m_tvalid;
	logic        m_tready    = 1'b0;
	logic [31:0] m_tdata;            // return_day, return_month, return_year, return_weekday
	logic [0:0]  m_tuser;            // bad_date

	// weekend days as the block holds them, and the dates still owed
	logic [6:0] weekend_days = bdda_pkg::WEEKEND_RESET;
	return_t    expected_returns[$];

	int send_idle_pct = 13;
	int recv_idle_pct = 62;
	int trips_sent      = 0;
	int returns_checked = 0;
	int bad_returns     = 0;
	int mismatches      = 0;
	int cycle_count     = 0;

	business_day_date_adder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	always #10 clk = ~clk;

	// gregorian leap rule
	function automatic bit is_leap(input int y);
		return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
	endfunction

	// length of a month, zero when the month code is out of range
	function automatic int month_length(input int y, input int m);
		int n;
		case (m)
			1, 3, 5, 7, 8, 10, 12: n = 31;
			4, 6, 9, 11:           n = 30;
			bdda_pkg::MONTH_FEB:   n = is_leap(y) ? 29 : 28;
			default:               n = 0;
		endcase
		return n;
	endfunction

	// weekday of a valid date, sunday first
	function automatic int weekday_of_date(input int d, input int m, input int y);
		int a;
		int yy;
		int mm;
		a  = (14 - m) / 12;
		yy = y - a;
		mm = m + 12 * a - 2;
		return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
	endfunction

	// next calendar day, zero when it would pass the last supported year
	function automatic bit step_date(input int d, input int m, input int y,
		output int nd, output int nm, output int ny);
		nd = d;
		nm = m;
		ny = y;
		if (d >= month_length(y, m)) begin
			nd = 1;
			if (m >= bdda_pkg::MONTH_DEC) begin
				if (y >= bdda_pkg::MAX_YEAR) begin
					return 1'b0;
				end
				nm = bdda_pkg::MONTH_JAN;
				ny = y + 1;
			end else begin
				nm = m + 1;
			end
		end else begin
			nd = d + 1;
		end
		return 1'b1;
	endfunction

	// return date for one vacation under the given weekend days
	function automatic return_t predict_return(input vacation_t v, input logic [6:0] wknd);
		int d;
		int m;
		int y;
		int wd;
		int counted;
		int target;
		bit bad;
		return_t r;
		d       = v.day;
		m       = v.month;
		y       = v.year;
		wd      = bdda_pkg::WD_SUNDAY;
		counted = 0;
		bad     = 1'b0;
		target  = v.working_days;
		if (target > bdda_pkg::MAX_WORKING_DAYS) begin
			target = bdda_pkg::MAX_WORKING_DAYS;
		end
		if (y < 1 || y > bdda_pkg::MAX_YEAR || month_length(y, m) == 0 || d < 1 ||
			d > month_length(y, m)) begin
			bad = 1'b1;
		end else begin
			wd = weekday_of_date(d, m, y);
			if (wknd == bdda_pkg::WEEKEND_ALL) begin
				bad = 1'b1;
			end else begin
				// count off working days, starting on the first day itself
				while (!bad && counted < target) begin
					if (!wknd[wd]) begin
						counted++;
					end
					if (!step_date(d, m, y, d, m, y)) begin
						bad = 1'b1;
					end else begin
						wd = (wd + 1) % 7;
					end
				end
				// then roll past any weekend
				while (!bad && wknd[wd]) begin
					if (!step_date(d, m, y, d, m, y)) begin
						bad = 1'b1;
					end else begin
						wd = (wd + 1) % 7;
					end
				end
				if (bad) begin
					wd = weekday_of_date(v.day, v.month, v.year);
				end
			end
		end
		if (bad) begin
			d = v.day;
			m = v.month;
			y = v.year;
		end
		r.day     = d[4:0];
		r.month   = m[3:0];
		r.year    = y[13:0];
		r.weekday = wd[2:0];
		r.bad     = bad;
		return r;
	endfunction

	function automatic vacation_t vacation(input int d, input int m, input int y, input int w);
		vacation_t v;
		v.day          = d[4:0];
		v.month        = m[3:0];
		v.year         = y[13:0];
		v.working_days = w[11:0];
		return v;
	endfunction

	// mostly valid dates with short counts, a few long counts, some raw noise
	function automatic vacation_t random_vacation();
		int pick;
		int y;
		int m;
		int d;
		int w;
		pick = $urandom_range(99);
		if (pick < 12) begin
			y = $urandom_range(16383);
			m = $urandom_range(15);
			d = $urandom_range(31);
		end else begin
			case ($urandom_range(9))
				0:       y = $urandom_range(9985, 9999);
				1:       y = $urandom_range(1, 20);
				default: y = $urandom_range(1, 9999);
			endcase
			m = $urandom_range(bdda_pkg::MONTH_JAN, bdda_pkg::MONTH_DEC);
			if (pick < 18) begin
				d = $urandom_range(31);
			end else begin
				d = $urandom_range(1, month_length(y, m));
			end
		end
		if ($urandom_range(99) < 5) begin
			w = $urandom_range(4095);
		end else begin
			w = $urandom_range(80);
		end
		return vacation(d, m, y, w);
	endfunction

	// offer one item, sometimes with a random gap ahead of it
	task automatic send_vacation(input vacation_t v);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, v.working_days, v.year, v.month, v.day};
		do @(posedge clk); while (!s_tready);
		expected_returns.push_back(predict_return(v, weekend_days));
		trips_sent++;
	endtask

	task automatic wait_returns_drained();
		s_tvalid <= 1'b0;
		while (expected_returns.size() != 0) @(posedge clk);
	endtask

	// weekend mask is only written with nothing in flight
	task automatic write_weekend(input logic [6:0] wknd);
		wait_returns_drained();
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= wknd;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		weekend_days  = wknd;
	endtask

	task automatic check_field(input string what, input logic [13:0] want,
		input logic [13:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	// leap days, month and year rollover, zero and full counts
	task automatic test_calendar_edges();
		send_vacation(vacation(1, 1, 1, 0));
		send_vacation(vacation(1, 1, 1, 4095));
		send_vacation(vacation(29, 2, 2000, 10));
		send_vacation(vacation(29, 2, 2024, 1));
		send_vacation(vacation(31, 12, 1999, 1));
		send_vacation(vacation(28, 2, 2100, 3));
		send_vacation(vacation(31, 1, 2023, 5));
	endtask

	// every way a start date can be invalid
	task automatic test_bad_dates();
		send_vacation(vacation(29, 2, 1900, 5));
		send_vacation(vacation(29, 2, 2023, 0));
		send_vacation(vacation(0, 1, 2020, 1));
		send_vacation(vacation(31, 4, 2020, 1));
		send_vacation(vacation(31, 15, 2020, 7));
		send_vacation(vacation(1, 0, 2020, 1));
		send_vacation(vacation(1, 13, 2020, 1));
		send_vacation(vacation(1, 1, 0, 1));
		send_vacation(vacation(1, 1, 10000, 1));
		send_vacation(vacation(31, 15, 16383, 4095));
	endtask

	// stepping past the last day of year 9999
	task automatic test_year_overflow();
		send_vacation(vacation(31, 12, 9999, 0));
		send_vacation(vacation(20, 12, 9999, 100));
		send_vacation(vacation(1, 1, 9984, 4095));
	endtask

	// no weekend at all, then every day a weekend
	task automatic test_mask_extremes();
		write_weekend(7'd0);
		send_vacation(vacation(31, 12, 9999, 0));
		send_vacation(vacation(15, 6, 1234, 4095));
		write_weekend(bdda_pkg::WEEKEND_ALL);
		send_vacation(vacation(15, 6, 1234, 3));
		send_vacation(vacation(0, 0, 0, 0));
	endtask

	task automatic test_random_vacations(input int count, input int send_pct,
		input int recv_pct, input logic [6:0] wknd);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		write_weekend(wknd);
		for (int i = 0; i < count; i++) begin
			send_vacation(random_vacation());
		end
	endtask

	// compare each returned item with the oldest prediction
	always @(posedge clk) begin : check_returns
		return_t got;
		return_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			got = {m_tdata[4:0], m_tdata[8:5], m_tdata[22:9], m_tdata[25:23], m_tuser[0]};
			if (expected_returns.size() == 0) begin
				$display("%0t: unexpected return, expected none, actual %0d-%0d-%0d bad %0b",
					$time, got.year, got.month, got.day, got.bad);
				mismatches++;
			end else begin
				want = expected_returns.pop_front();
				check_field("return_day", 14'(want.day), 14'(got.day));
				check_field("return_month", 14'(want.month), 14'(got.month));
				check_field("return_year", want.year, got.year);
				check_field("return_weekday", 14'(want.weekday), 14'(got.weekday));
				check_field("bad_date", 14'(want.bad), 14'(got.bad));
				returns_checked++;
				if (want.bad) begin
					bad_returns++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d returns outstanding", cycle_count,
				expected_returns.size());
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_calendar_edges();
		test_bad_dates();
		test_year_overflow();
		test_mask_extremes();
		test_random_vacations(26, 13, 62, 7'b1000001);
		test_random_vacations(26, 62, 13, 7'($urandom_range(0, 126)));
		test_random_vacations(26, 0, 0, bdda_pkg::WEEKEND_RESET);
		wait_returns_drained();
		repeat (40) @(posedge clk);
		$display("%0d vacations sent, %0d return dates checked, %0d of them flagged bad",
			trips_sent, returns_checked, bad_returns);
		$display("covered leap days, rollovers, invalid dates, year overflow, masks 0 to 127");
		if (mismatches == 0 && expected_returns.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
